// ===== rtl/grsr_pkg.sv =====
// ----------------------------------------------------------------------------
// grsr_pkg
// shared types and constants of the glyph row smoothing renderer
// ----------------------------------------------------------------------------
package grsr_pkg;

	localparam int CELL_WIDTH  = 7;
	localparam int COLOR_W     = 24;
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = COLOR_W / CHAN_W;
	localparam int CFG_INDEX_W = 2;

	// divide by ten as multiply by 6554 and drop 16 bits, exact for sums up to 2550
	localparam int DIV10_RECIP_W = 13;
	localparam logic [DIV10_RECIP_W-1:0] DIV10_RECIP = 13'd6554;
	localparam int DIV10_SHIFT = 16;

	typedef logic [CELL_WIDTH-1:0] row_t;
	typedef logic [COLOR_W-1:0]    color_t;

	localparam color_t FG_RESET      = 24'h000000;
	localparam color_t BG_RESET      = 24'hAAAAAA;
	localparam logic   DRAW_BG_RESET = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FG_COLOR = 2'd0,
		REG_BG_COLOR = 2'd1,
		REG_DRAW_BG  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		color_t fg;
		color_t bg;
		logic   draw_bg;
	} cfg_t;

	// one emitted row: color[c] is column c, col 0 leftmost
	typedef struct packed {
		color_t [CELL_WIDTH-1:0] color;
		row_t                    wr_mask;
		logic                    done;
	} row_word_t;

endpackage

// ===== rtl/grsr_render.sv =====
// ----------------------------------------------------------------------------
// grsr_render
// colors and write mask of one glyph row from its upper and lower neighbors
// ----------------------------------------------------------------------------
module grsr_render (
	input  grsr_pkg::row_t      above,
	input  grsr_pkg::row_t      cur,
	input  grsr_pkg::row_t      below,
	input  logic                done,
	input  grsr_pkg::cfg_t      cfg,
	output grsr_pkg::row_word_t word
);

	localparam int W     = grsr_pkg::CELL_WIDTH;
	localparam int CW    = grsr_pkg::CHAN_W;
	localparam int SUM_W = CW + 4;
	localparam int PRD_W = SUM_W + grsr_pkg::DIV10_RECIP_W;

	grsr_pkg::row_t   side;
	grsr_pkg::row_t   blend;
	grsr_pkg::color_t mix;
	logic [SUM_W-1:0] chan_sum [grsr_pkg::NUM_CHAN];
	logic [PRD_W-1:0] chan_prd [grsr_pkg::NUM_CHAN];

	// per channel floor((3*fg + 7*bg) / 10)
	always_comb begin
		for (int ch = 0; ch < grsr_pkg::NUM_CHAN; ch++) begin
			chan_sum[ch] = SUM_W'({cfg.fg[ch*CW +: CW], 1'b0}) + SUM_W'(cfg.fg[ch*CW +: CW])
				+ SUM_W'({cfg.bg[ch*CW +: CW], 3'b000}) - SUM_W'(cfg.bg[ch*CW +: CW]);
			chan_prd[ch] = PRD_W'(chan_sum[ch]) * PRD_W'(grsr_pkg::DIV10_RECIP);
			mix[ch*CW +: CW] = chan_prd[ch][grsr_pkg::DIV10_SHIFT +: CW];
		end
	end

	// diagonal step: clear pixel with a set side neighbor and a set pixel above or below
	assign side  = {cur[W-2:0], 1'b0} | {1'b0, cur[W-1:1]};
	assign blend = ~cur & side & (above | below);

	always_comb begin
		word.done    = done;
		word.wr_mask = '0;
		for (int c = 0; c < W; c++) begin
			if (cur[W-1-c]) begin
				word.color[c]       = cfg.fg;
				word.wr_mask[W-1-c] = 1'b1;
			end else if (blend[W-1-c]) begin
				word.color[c]       = mix;
				word.wr_mask[W-1-c] = 1'b1;
			end else if (cfg.draw_bg) begin
				word.color[c]       = cfg.bg;
				word.wr_mask[W-1-c] = 1'b1;
			end else begin
				word.color[c] = '0;
			end
		end
	end

endmodule

// ===== rtl/glyph_row_smoothing_renderer_top.sv =====
// ----------------------------------------------------------------------------
// glyph_row_smoothing_renderer_top
// smooths glyph rows and emits each row's pixel colors one row late
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | glyph_bits, final_row
//  out     | out_valid / out_ready  | color_col0..6, write_enable, cell_done
//  cfg     | cfg_write_en           | cfg_index, cfg_data
//
//  an input word lands in the s1 register and is rendered from there into the
//  output register, so a row's result is registered once its lower neighbor is in s1
//  one input word per cycle unless s1 is held; a final row after a held row makes
//  two output words and holds s1 until the single output register takes the second
//  the first row of a glyph, unless it is also final, makes no output word and never waits on out_ready
//  out_ready low stalls the output register, then s1 if its row needs an output word, then in_ready
//  reset clears the row history, both valid flags and the configuration registers
// ----------------------------------------------------------------------------
module glyph_row_smoothing_renderer_top (
	input  logic                   clk,
	input  logic                   arst_n,
	// input words
	input  logic                   in_valid,
	output logic                   in_ready,
	input  grsr_pkg::row_t         glyph_bits,
	input  logic                   final_row,
	// output words
	output logic                   out_valid,
	input  logic                   out_ready,
	output grsr_pkg::color_t       color_col0,
	output grsr_pkg::color_t       color_col1,
	output grsr_pkg::color_t       color_col2,
	output grsr_pkg::color_t       color_col3,
	output grsr_pkg::color_t       color_col4,
	output grsr_pkg::color_t       color_col5,
	output grsr_pkg::color_t       color_col6,
	output grsr_pkg::row_t         write_enable,
	output logic                   cell_done,
	// configuration writes
	input  logic                   cfg_write_en,
	input  grsr_pkg::cfg_reg_t     cfg_index,
	input  grsr_pkg::color_t       cfg_data
);

	// configuration registers
	grsr_pkg::cfg_t cfg_q;

	// input stage
	logic           valid_s1;
	grsr_pkg::row_t bits_s1;
	logic           final_s1;

	// row history: row above the held row, the held row, held flag
	grsr_pkg::row_t above_q;
	grsr_pkg::row_t pend_q;
	logic           pvalid_q;

	// output register
	logic                valid_s2;
	grsr_pkg::row_word_t word_s2;

	logic                need_out;
	logic                out_free;
	logic                go;
	logic                consume;
	logic                two_words;
	grsr_pkg::row_t      r_above;
	grsr_pkg::row_t      r_cur;
	grsr_pkg::row_t      r_below;
	logic                r_done;
	grsr_pkg::row_word_t word_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg      <= grsr_pkg::FG_RESET;
			cfg_q.bg      <= grsr_pkg::BG_RESET;
			cfg_q.draw_bg <= grsr_pkg::DRAW_BG_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				grsr_pkg::REG_FG_COLOR: cfg_q.fg      <= cfg_data;
				grsr_pkg::REG_BG_COLOR: cfg_q.bg      <= cfg_data;
				grsr_pkg::REG_DRAW_BG:  cfg_q.draw_bg <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a held row always emits; a lone row emits only when it is the final one
	assign need_out  = pvalid_q | final_s1;
	assign out_free  = !valid_s2 || out_ready;
	assign go        = valid_s1 && (!need_out || out_free);
	// final row after a held row: first word is the held row, s1 stays for the second
	assign two_words = pvalid_q && final_s1;
	assign consume   = go && !two_words;
	assign in_ready  = !valid_s1 || consume;

	// held row over the new one, or the new final row over a clear row
	always_comb begin
		if (pvalid_q) begin
			r_above = above_q;
			r_cur   = pend_q;
			r_below = bits_s1;
			r_done  = 1'b0;
		end else begin
			r_above = above_q;
			r_cur   = bits_s1;
			r_below = '0;
			r_done  = 1'b1;
		end
	end

	grsr_render u_render (
		.above (r_above),
		.cur   (r_cur),
		.below (r_below),
		.done  (r_done),
		.cfg   (cfg_q),
		.word  (word_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bits_s1  <= glyph_bits;
			final_s1 <= final_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q  <= '0;
			pend_q   <= '0;
			pvalid_q <= 1'b0;
		end else if (go) begin
			if (pvalid_q) begin
				above_q <= pend_q;
				if (final_s1) begin
					// second word of the cell is rendered from s1 once the output register is free
					pvalid_q <= 1'b0;
				end else begin
					pend_q <= bits_s1;
				end
			end else if (final_s1) begin
				// cell finished, clear the history
				above_q <= '0;
				pend_q  <= '0;
			end else begin
				pend_q   <= bits_s1;
				pvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= go && need_out;
		end
	end

	always_ff @(posedge clk) begin
		if (go && need_out) begin
			word_s2 <= word_next;
		end
	end

	assign out_valid    = valid_s2;
	assign color_col0   = word_s2.color[0];
	assign color_col1   = word_s2.color[1];
	assign color_col2   = word_s2.color[2];
	assign color_col3   = word_s2.color[3];
	assign color_col4   = word_s2.color[4];
	assign color_col5   = word_s2.color[5];
	assign color_col6   = word_s2.color[6];
	assign write_enable = word_s2.wr_mask;
	assign cell_done    = word_s2.done;

	// history is clear unless a row is held or the second word of a cell waits
	a_history_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!pvalid_q && !(valid_s1 && final_s1) |-> above_q == '0)
		else $error("row above not cleared between cells");

	// the first of two words leaves the final row in s1 with nothing held
	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		go && two_words |=> valid_s1 && final_s1 && !pvalid_q)
		else $error("second word of a cell lost");

	// with background on, every pixel of an emitted row is written
	a_full_mask: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cfg_q.draw_bg |-> word_s2.wr_mask == '1)
		else $error("write mask incomplete with background on");

	// an output word marked done carries no held row behind it
	a_done_flush: assert property (@(posedge clk) disable iff (!arst_n)
		go && need_out && r_done |=> !pvalid_q && above_q == '0)
		else $error("history kept after the last row of a cell");

endmodule
